// ===== hw/rtl/pqt_pkg.sv =====
// pqt_pkg: shared codes, defaults and the cell control struct for the
// sorted priority queue. No dependencies.
`timescale 1ns / 1ps

package pqt_pkg;

  localparam int unsigned DefQueueDepth  = 16;
  localparam int unsigned DefPayloadBits = 32;

  localparam int unsigned OpcodeBits = 2;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned PrioBits   = 8;
  localparam int unsigned WordBits   = 32;
  localparam int unsigned OccBits    = 5;

  localparam logic [OpcodeBits-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OpcodeBits-1:0] OP_HEAD    = 2'd1;
  localparam logic [OpcodeBits-1:0] OP_EXACT   = 2'd2;
  localparam logic [OpcodeBits-1:0] OP_THRESH  = 2'd3;

  localparam logic [StatusBits-1:0] ST_DONE  = 2'd0;
  localparam logic [StatusBits-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusBits-1:0] ST_FULL  = 2'd2;

  // broadcast from the controller to every cell of the chain
  typedef struct packed {
    logic eval;        // capture compare flags against the key
    logic enq;         // open a gap and insert the new entry
    logic shift_all;   // every cell takes its right neighbor
    logic shift_tail;  // cells from the first match on take their right neighbor
  } pqt_ctrl_t;

endpackage

// ===== hw/rtl/priority_queue_table.sv =====
// priority_queue_table: each accepted operation has an evaluate phase, in which every cell compares
// its priority with the key, then a commit phase, in which the chain shifts and the result register
// loads. A new request is taken only when idle or in the commit phase of the last one, never before.
// A result that is not taken holds the chain in its commit phase.
// Reset clears the valid bits, the entry count and the handshake; entry data is not reset.
// Depends on pqt_pkg and pqt_cell.
`timescale 1ns / 1ps

module priority_queue_table import pqt_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH  = DefQueueDepth,
  parameter int unsigned PAYLOAD_BITS = DefPayloadBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [OpcodeBits-1:0] opcode_i,
  input  logic [PrioBits-1:0]   priority_key_i,
  input  logic [WordBits-1:0]   payload_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [StatusBits-1:0] status_o,
  output logic                  found_o,
  output logic [PrioBits-1:0]   priority_out_o,
  output logic [WordBits-1:0]   payload_out_o,
  output logic [OccBits-1:0]    occupancy_o
);

  localparam int unsigned CntBits = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntBits-1:0] CntFull = CntBits'(QUEUE_DEPTH);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_EVAL   = 2'd1;
  localparam logic [1:0] PH_COMMIT = 2'd2;

  logic [1:0]              phase_q, phase_d;
  logic [OpcodeBits-1:0]   op_q;
  logic [PrioBits-1:0]     key_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [CntBits-1:0]      count_q, count_d;

  logic                    out_valid_q;
  logic [StatusBits-1:0]   res_status_q, res_status_d;
  logic                    res_found_q, res_found_d;
  logic [PrioBits-1:0]     res_prio_q, res_prio_d;
  logic [WordBits-1:0]     res_pay_q;
  logic [PAYLOAD_BITS-1:0] res_pay_d;
  logic [CntBits-1:0]      res_cnt_q;

  logic                    accept, commit, full, exact_found;
  logic [63:0]             pay_in_ext, pay_out_ext;
  logic [PAYLOAD_BITS-1:0] hit_pay;
  pqt_ctrl_t               ctrl;

  logic [QUEUE_DEPTH-1:0]  valid_vec, ge_vec, eq_vec;
  logic [PrioBits-1:0]     cell_prio [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_pay  [QUEUE_DEPTH];

  assign commit     = (phase_q == PH_COMMIT) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (phase_q == PH_IDLE) || commit;
  assign accept     = in_valid_i && in_ready_o;

  assign full        = (count_q == CntFull);
  assign exact_found = |eq_vec;
  assign pay_in_ext  = 64'(payload_in_i);

  always_comb begin
    ctrl            = '0;
    ctrl.eval       = (phase_q == PH_EVAL);
    ctrl.enq        = commit && (op_q == OP_ENQUEUE) && !full;
    ctrl.shift_all  = commit && (((op_q == OP_HEAD) && valid_vec[0]) ||
                                 ((op_q == OP_THRESH) && ge_vec[0]));
    ctrl.shift_tail = commit && (op_q == OP_EXACT) && exact_found;
  end

  // equal priorities sit side by side, so the first match has no match on its left
  always_comb begin
    hit_pay = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (eq_vec[i] && ((i == 0) || !eq_vec[(i == 0) ? 0 : i - 1])) begin
        hit_pay = hit_pay | cell_pay[i];
      end
    end
  end

  always_comb begin
    res_status_d = ST_EMPTY;
    res_found_d  = 1'b0;
    res_prio_d   = '0;
    res_pay_d    = '0;
    count_d      = count_q;
    unique case (op_q)
      OP_ENQUEUE: begin
        if (full) begin
          res_status_d = ST_FULL;
        end else begin
          res_status_d = ST_DONE;
          count_d      = CntBits'(count_q + CntBits'(1));
        end
      end
      OP_HEAD, OP_THRESH: begin
        if ((op_q == OP_HEAD) ? valid_vec[0] : ge_vec[0]) begin
          res_status_d = ST_DONE;
          res_found_d  = 1'b1;
          res_prio_d   = cell_prio[0];
          res_pay_d    = cell_pay[0];
          count_d      = CntBits'(count_q - CntBits'(1));
        end
      end
      OP_EXACT: begin
        if (exact_found) begin
          res_status_d = ST_DONE;
          res_found_d  = 1'b1;
          res_prio_d   = key_q;
          res_pay_d    = hit_pay;
          count_d      = CntBits'(count_q - CntBits'(1));
        end
      end
      default: ;
    endcase
  end

  assign pay_out_ext = 64'(res_pay_d);

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_IDLE:   if (in_valid_i) phase_d = PH_EVAL;
      PH_EVAL:   phase_d = PH_COMMIT;
      PH_COMMIT: begin
        if (commit) phase_d = in_valid_i ? PH_EVAL : PH_IDLE;
      end
      default:   phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_i;
      key_q <= priority_key_i;
      pay_q <= pay_in_ext[PAYLOAD_BITS-1:0];
    end
    if (commit) begin
      res_status_q <= res_status_d;
      res_found_q  <= res_found_d;
      res_prio_q   <= res_prio_d;
      res_pay_q    <= pay_out_ext[WordBits-1:0];
      res_cnt_q    <= count_d;
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic                    l_ge, l_valid, r_valid;
    logic [PrioBits-1:0]     l_prio, r_prio;
    logic [PAYLOAD_BITS-1:0] l_pay, r_pay;

    if (g == 0) begin : g_head
      assign l_ge    = 1'b1;
      assign l_valid = 1'b0;
      assign l_prio  = '0;
      assign l_pay   = '0;
    end else begin : g_mid
      assign l_ge    = ge_vec[g-1];
      assign l_valid = valid_vec[g-1];
      assign l_prio  = cell_prio[g-1];
      assign l_pay   = cell_pay[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_prio  = '0;
      assign r_pay   = '0;
    end else begin : g_body
      assign r_valid = valid_vec[g+1];
      assign r_prio  = cell_prio[g+1];
      assign r_pay   = cell_pay[g+1];
    end

    pqt_cell #(
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .key_i          (key_q),
      .new_payload_i  (pay_q),
      .left_ge_i      (l_ge),
      .left_valid_i   (l_valid),
      .left_prio_i    (l_prio),
      .left_payload_i (l_pay),
      .right_valid_i  (r_valid),
      .right_prio_i   (r_prio),
      .right_payload_i(r_pay),
      .valid_o        (valid_vec[g]),
      .prio_o         (cell_prio[g]),
      .payload_o      (cell_pay[g]),
      .ge_o           (ge_vec[g]),
      .eq_o           (eq_vec[g])
    );
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = res_status_q;
  assign found_o        = res_found_q;
  assign priority_out_o = res_prio_q;
  assign payload_out_o  = res_pay_q;
  assign occupancy_o    = OccBits'(res_cnt_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("entry count above queue depth");

  a_no_accept_in_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_EVAL) |-> !in_ready_o)
    else $error("request taken while compare flags are pending");

  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (status_o == ST_DONE))
    else $error("removed entry presented with a failing status");

  a_count_matches_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> ($countones(valid_vec) == int'(count_q)))
    else $error("valid cells disagree with entry count");

endmodule

// ===== hw/rtl/pqt_cell.sv =====
// pqt_cell: one slot of the sorted chain; holds an entry and its compare
// flags, and moves data to and from its neighbors. Depends on pqt_pkg.
`timescale 1ns / 1ps

module pqt_cell import pqt_pkg::*; #(
  parameter int unsigned PAYLOAD_BITS = DefPayloadBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pqt_ctrl_t               ctrl_i,
  input  logic [PrioBits-1:0]     key_i,
  input  logic [PAYLOAD_BITS-1:0] new_payload_i,
  input  logic                    left_ge_i,
  input  logic                    left_valid_i,
  input  logic [PrioBits-1:0]     left_prio_i,
  input  logic [PAYLOAD_BITS-1:0] left_payload_i,
  input  logic                    right_valid_i,
  input  logic [PrioBits-1:0]     right_prio_i,
  input  logic [PAYLOAD_BITS-1:0] right_payload_i,
  output logic                    valid_o,
  output logic [PrioBits-1:0]     prio_o,
  output logic [PAYLOAD_BITS-1:0] payload_o,
  output logic                    ge_o,
  output logic                    eq_o
);

  logic                    valid_q, valid_d;
  logic [PrioBits-1:0]     prio_q, prio_d;
  logic [PAYLOAD_BITS-1:0] payload_q, payload_d;
  logic                    ge_q, ge_d, gt_q, gt_d, eq_q, eq_d;

  always_comb begin
    ge_d = ge_q;
    gt_d = gt_q;
    eq_d = eq_q;
    if (ctrl_i.eval) begin
      ge_d = valid_q && (prio_q >= key_i);
      gt_d = valid_q && (prio_q > key_i);
      eq_d = valid_q && (prio_q == key_i);
    end
  end

  always_comb begin
    priority if (ctrl_i.enq && !ge_q) begin
      // first cell below the key takes the new entry, the rest move right
      if (left_ge_i) begin
        valid_d   = 1'b1;
        prio_d    = key_i;
        payload_d = new_payload_i;
      end else begin
        valid_d   = left_valid_i;
        prio_d    = left_prio_i;
        payload_d = left_payload_i;
      end
    end else if (ctrl_i.shift_all || (ctrl_i.shift_tail && !gt_q)) begin
      valid_d   = right_valid_i;
      prio_d    = right_prio_i;
      payload_d = right_payload_i;
    end else begin
      valid_d   = valid_q;
      prio_d    = prio_q;
      payload_d = payload_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ge_q    <= 1'b0;
      gt_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      ge_q    <= ge_d;
      gt_q    <= gt_d;
      eq_q    <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q    <= prio_d;
    payload_q <= payload_d;
  end

  assign valid_o   = valid_q;
  assign prio_o    = prio_q;
  assign payload_o = payload_q;
  assign ge_o      = ge_q;
  assign eq_o      = eq_q;

endmodule

// ===== tb/tb_priority_queue_table.sv =====
// tb_priority_queue_table: self-checking bench for the sorted priority queue; a directed
// pass then random fill/drain traffic, with each result checked against a behavioral table.
// Depends on pqt_pkg and priority_queue_table.
`timescale 1ns / 1ps

module tb_priority_queue_table;
  import pqt_pkg::*;

  localparam int unsigned Depth         = DefQueueDepth;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned LongStall     = 300;
  localparam int unsigned SettleCycles  = 10;

  typedef struct packed {
    logic [OpcodeBits-1:0] opcode;
    logic [PrioBits-1:0]   key;
    logic [WordBits-1:0]   payload;
  } pq_request_t;

  typedef struct packed {
    logic [StatusBits-1:0] status;
    logic                  found;
    logic [PrioBits-1:0]   prio;
    logic [WordBits-1:0]   payload;
    logic [OccBits-1:0]    occ;
  } pq_result_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready_o;
  logic [OpcodeBits-1:0] opcode         = OP_ENQUEUE;
  logic [PrioBits-1:0]   priority_key   = '0;
  logic [WordBits-1:0]   payload_in     = '0;
  logic                  out_valid_o;
  logic                  out_ready      = 1'b0;
  logic [StatusBits-1:0] status_o;
  logic                  found_o;
  logic [PrioBits-1:0]   priority_out_o;
  logic [WordBits-1:0]   payload_out_o;
  logic [OccBits-1:0]    occupancy_o;

  priority_queue_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode),
    .priority_key_i (priority_key),
    .payload_in_i   (payload_in),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .status_o       (status_o),
    .found_o        (found_o),
    .priority_out_o (priority_out_o),
    .payload_out_o  (payload_out_o),
    .occupancy_o    (occupancy_o)
  );

  // shadow of the sorted table, highest priority at index 0
  logic [PrioBits-1:0] table_prio    [Depth];
  logic [WordBits-1:0] table_payload [Depth];
  int unsigned         table_count = 0;

  pq_request_t pending_requests [$];
  pq_result_t  expected_results [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned stall_requests = 0;
  int unsigned stall_served   = 0;
  int unsigned stall_left     = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic pq_result_t apply_request(pq_request_t req);
    pq_result_t res;
    int         pos;
    int         hit;
    int         i;
    res = '{status: ST_EMPTY, found: 1'b0, prio: '0, payload: '0, occ: '0};
    hit = -1;
    case (req.opcode)
      OP_ENQUEUE: begin
        if (table_count >= Depth) begin
          res.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < table_count && table_prio[pos] >= req.key) pos++;
          for (i = table_count; i > pos; i--) begin
            table_prio[i]    = table_prio[i-1];
            table_payload[i] = table_payload[i-1];
          end
          table_prio[pos]    = req.key;
          table_payload[pos] = req.payload;
          table_count++;
          res.status = ST_DONE;
        end
      end
      OP_HEAD: begin
        if (table_count != 0) hit = 0;
      end
      OP_EXACT: begin
        for (i = 0; i < table_count; i++) begin
          if (hit < 0 && table_prio[i] == req.key) hit = i;
        end
      end
      default: begin
        // only the head is tested; the order is descending
        if (table_count != 0 && table_prio[0] >= req.key) hit = 0;
      end
    endcase
    if (hit >= 0) begin
      res.status  = ST_DONE;
      res.found   = 1'b1;
      res.prio    = table_prio[hit];
      res.payload = table_payload[hit];
      for (i = hit; i + 1 < table_count; i++) begin
        table_prio[i]    = table_prio[i+1];
        table_payload[i] = table_payload[i+1];
      end
      table_count--;
    end
    res.occ = table_count[OccBits-1:0];
    return res;
  endfunction

  function automatic void check_field(string name, logic [WordBits-1:0] want,
                                      logic [WordBits-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    pq_request_t req;
    if (!rst_ni) begin
      in_valid     <= 1'b0;
      opcode       <= OP_ENQUEUE;
      priority_key <= '0;
      payload_in   <= '0;
    end else begin
      if (in_valid && in_ready_o) begin
        expected_results.push_back(apply_request('{opcode, priority_key, payload_in}));
      end
      if (!in_valid || in_ready_o) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req = pending_requests.pop_front();
          in_valid     <= 1'b1;
          opcode       <= req.opcode;
          priority_key <= req.key;
          payload_in   <= req.payload;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    pq_result_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", WordBits'(want.status), WordBits'(status_o));
          check_field("found", WordBits'(want.found), WordBits'(found_o));
          check_field("priority_out", WordBits'(want.prio), WordBits'(priority_out_o));
          check_field("payload_out", want.payload, payload_out_o);
          check_field("occupancy", WordBits'(want.occ), WordBits'(occupancy_o));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (stall_served != stall_requests) begin
        // long hold-off so the block backs up and stalls its input
        stall_served++;
        stall_left = LongStall;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("priority_queue_table regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void push_request(logic [OpcodeBits-1:0] op, logic [PrioBits-1:0] key,
                                       logic [WordBits-1:0] payload);
    pending_requests.push_back('{opcode: op, key: key, payload: payload});
  endfunction

  // narrow keys give ties and exact matches
  function automatic void push_segment(int unsigned count, int unsigned enq_pct, bit narrow);
    logic [OpcodeBits-1:0] op;
    logic [PrioBits-1:0]   key;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(99) < enq_pct) begin
        op = OP_ENQUEUE;
      end else begin
        case ($urandom_range(2))
          0:       op = OP_HEAD;
          1:       op = OP_EXACT;
          default: op = OP_THRESH;
        endcase
      end
      key = narrow ? PrioBits'($urandom_range(3) * 85) : PrioBits'($urandom_range(255));
      push_request(op, key, $urandom);
    end
  endfunction

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 20;
    recv_idle_pct = 56;

    // removals on an empty queue
    push_request(OP_HEAD, 8'd0, 32'h0);
    push_request(OP_EXACT, 8'd0, 32'h0);
    push_request(OP_THRESH, 8'd0, 32'h0);
    // extremes, ties in the middle and at the bottom
    push_request(OP_ENQUEUE, 8'd0, 32'h0000_0000);
    push_request(OP_ENQUEUE, 8'd255, 32'hffff_ffff);
    push_request(OP_ENQUEUE, 8'd128, 32'ha5a5_a5a5);
    push_request(OP_ENQUEUE, 8'd128, 32'h5a5a_5a5a);
    push_request(OP_ENQUEUE, 8'd0, 32'h0000_0001);
    push_request(OP_ENQUEUE, 8'd64, 32'h1234_5678);
    // threshold equal to head, threshold above head, oldest of a tie first
    push_request(OP_THRESH, 8'd255, 32'h0);
    push_request(OP_THRESH, 8'd200, 32'h0);
    push_request(OP_THRESH, 8'd128, 32'h0);
    push_request(OP_EXACT, 8'd128, 32'h0);
    push_request(OP_EXACT, 8'd77, 32'h0);
    push_request(OP_EXACT, 8'd0, 32'h0);
    push_request(OP_HEAD, 8'd0, 32'h0);
    push_request(OP_THRESH, 8'd0, 32'h0);
    push_request(OP_HEAD, 8'd0, 32'h0);
    wait_drained();

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 56;
          stall_requests++;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      push_segment(40, 85, 1'b1);
      push_segment(40, 15, 1'b0);
      push_segment(40, 80, 1'b0);
      push_segment(40, 20, 1'b1);
      push_segment(56, 50, mode[0]);
      // sender holds until every outstanding result is back
      wait_drained();
    end

    repeat (SettleCycles) @(negedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("priority_queue_table regression: pass");
    end else begin
      $display("priority_queue_table regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pqt_pkg.sv
hw/rtl/pqt_cell.sv
hw/rtl/priority_queue_table.sv
tb/tb_priority_queue_table.sv
